// ===== design/pwu_pkg.sv =====
// ----------------------------------------------------------------------------
// pwu_pkg
// Shared types, widths and defaults for the predictor weight update block.
// ----------------------------------------------------------------------------
package pwu_pkg;

  localparam int unsigned DEF_MAX_BANDS      = 256;
  localparam int unsigned DEF_MAX_COMPONENTS = 18;

  localparam int unsigned BAND_W     = 8;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COMP_W     = 5;
  localparam int unsigned DIFF_W     = 35;
  localparam int unsigned OFF_W      = 4;
  localparam int unsigned WEIGHT_W   = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // sign-corrected difference, exponent and scaled difference widths
  localparam int unsigned V_W        = DIFF_W + 1;
  localparam int unsigned E_W        = 8;
  localparam int unsigned SCALE_LOG2 = 40;
  localparam int unsigned SV_W       = SCALE_LOG2 + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECEDING_BANDS   = 3'd0,
    CFG_WEIGHT_RESOLUTION = 3'd1,
    CFG_FULL_MODE         = 3'd2,
    CFG_ROW_WIDTH         = 3'd3,
    CFG_INTERVAL_LOG2     = 3'd4,
    CFG_EXPONENT_FLOOR    = 3'd5,
    CFG_EXPONENT_CEILING  = 3'd6,
    CFG_SAMPLE_DEPTH      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ZERO,  // band or component outside the store
    OP_HOLD,  // inactive component, report stored weight
    OP_LOAD,  // init: write default value
    OP_ADD    // update: add scaled difference and clip
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [COMP_W-1:0] comp;
  } ctl_t;

endpackage

// ===== design/predictor_weight_update.sv =====
// ----------------------------------------------------------------------------
// predictor_weight_update
// Per-band weight vector store with init and adaptive update of one weight
// component per transaction.
// ----------------------------------------------------------------------------
// path: stage a, b, c, d and output registers; throughput: one transaction
//   per cycle unless the output stalls, set by the single read-modify-write
//   of the weight memory, with one-stage forwarding between adjacent items
// reset: clears pipeline valids and restores configuration defaults; the
//   weight memory is not cleared and reads back undefined until initialized
module predictor_weight_update #(
  parameter int unsigned MAX_BANDS      = pwu_pkg::DEF_MAX_BANDS,
  parameter int unsigned MAX_COMPONENTS = pwu_pkg::DEF_MAX_COMPONENTS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pwu_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pwu_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [pwu_pkg::BAND_W-1:0]           band_i,
  input  logic [pwu_pkg::COORD_W-1:0]          col_i,
  input  logic [pwu_pkg::COORD_W-1:0]          row_i,
  input  logic                                 error_negative_i,
  input  logic [pwu_pkg::COMP_W-1:0]           component_i,
  input  logic signed [pwu_pkg::DIFF_W-1:0]    local_difference_i,
  input  logic signed [pwu_pkg::OFF_W-1:0]     interband_offset_i,
  input  logic signed [pwu_pkg::OFF_W-1:0]     intraband_offset_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pwu_pkg::WEIGHT_W-1:0]  weight_o,
  output logic [pwu_pkg::COMP_W-1:0]           component_out_o,
  output logic                                 applied_o
);
  import pwu_pkg::*;

  localparam int unsigned DEPTH  = MAX_BANDS * MAX_COMPONENTS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned T_W    = 2 * COORD_W + 1;
  localparam int unsigned SUM_W  = SV_W + 1;

  // configuration
  logic [3:0]         pb_q;
  logic [4:0]         wr_q;
  logic               fm_q;
  logic [15:0]        rw_q;
  logic [3:0]         il_q;
  logic signed [4:0]  ef_q;
  logic signed [4:0]  ec_q;
  logic [5:0]         sd_q;
  logic [4:0]         res_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q <= 4'd3;
      wr_q <= 5'd13;
      fm_q <= 1'b1;
      rw_q <= 16'd256;
      il_q <= 4'd6;
      ef_q <= -5'sd1;
      ec_q <= 5'sd3;
      sd_q <= 6'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PRECEDING_BANDS:   pb_q <= cfg_data_i[3:0];
        CFG_WEIGHT_RESOLUTION: wr_q <= cfg_data_i[4:0];
        CFG_FULL_MODE:         fm_q <= cfg_data_i[0];
        CFG_ROW_WIDTH:         rw_q <= cfg_data_i[15:0];
        CFG_INTERVAL_LOG2:     il_q <= cfg_data_i[3:0];
        CFG_EXPONENT_FLOOR:    ef_q <= $signed(cfg_data_i[4:0]);
        CFG_EXPONENT_CEILING:  ec_q <= $signed(cfg_data_i[4:0]);
        CFG_SAMPLE_DEPTH:      sd_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wr_q < 5'd4) begin
      res_sat = 5'd4;
    end else if (wr_q > 5'd19) begin
      res_sat = 5'd19;
    end else begin
      res_sat = wr_q;
    end
  end

  // pipeline flow control
  logic v_a_q, v_b_q, v_c_q, v_d_q, out_valid_q;
  logic take_out, open_d, open_c, open_b, open_a, d_move, d_wr;

  assign take_out   = !out_valid_q || out_ready_i;
  assign open_d     = !v_d_q || take_out;
  assign open_c     = !v_c_q || open_d;
  assign open_b     = !v_b_q || open_c;
  assign open_a     = !v_a_q || open_b;
  assign d_move     = v_d_q && take_out;
  assign in_ready_o = open_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q       <= 1'b0;
      v_b_q       <= 1'b0;
      v_c_q       <= 1'b0;
      v_d_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (open_a)   v_a_q       <= in_valid_i;
      if (open_b)   v_b_q       <= v_a_q;
      if (open_c)   v_c_q       <= v_b_q;
      if (open_d)   v_d_q       <= v_c_q;
      if (take_out) out_valid_q <= v_d_q;
    end
  end

  // accept: classify the component and start the position product
  logic [3:0]          m_s;
  logic                inter_s, dir_s, in_range_s;
  op_e                 op_s;
  logic [31:0]         addr_full_s;
  logic [COORD_W-1:0]  rowm1_s;

  always_comb begin
    m_s        = (band_i < BAND_W'(pb_q)) ? band_i[3:0] : pb_q;
    inter_s    = component_i < COMP_W'(m_s);
    dir_s      = fm_q && (component_i >= COMP_W'(pb_q))
                 && (component_i < (COMP_W'(pb_q) + 5'd3));
    in_range_s = (32'(band_i) < 32'(MAX_BANDS))
                 && (32'(component_i) < 32'(MAX_COMPONENTS));
    if (!in_range_s) begin
      op_s = OP_ZERO;
    end else if (!func_i) begin
      op_s = ((component_i < COMP_W'(pb_q)) || dir_s) ? OP_LOAD : OP_HOLD;
    end else begin
      op_s = (inter_s || dir_s) ? OP_ADD : OP_HOLD;
    end
    addr_full_s = 32'(band_i) * 32'(MAX_COMPONENTS) + 32'(component_i);
    rowm1_s     = (row_i == '0) ? '0 : row_i - COORD_W'(1);
  end

  ctl_t                     ctl_a_q, ctl_b_q, ctl_c_q, ctl_d_q;
  logic [ADDR_W-1:0]        addr_a_q, addr_b_q, addr_c_q, addr_d_q;
  logic                     inter_a_q;
  logic signed [OFF_W-1:0]  off_a_q, off_b_q;
  logic [2*COORD_W-1:0]     prod_a_q;
  logic [COORD_W-1:0]       col_a_q;
  logic                     neg_a_q;
  logic signed [DIFF_W-1:0] diff_a_q;

  always_ff @(posedge clk_i) begin
    if (open_a) begin
      ctl_a_q   <= '{op: op_s, comp: component_i};
      addr_a_q  <= addr_full_s[ADDR_W-1:0];
      inter_a_q <= inter_s;
      off_a_q   <= inter_s ? interband_offset_i : intraband_offset_i;
      prod_a_q  <= (2*COORD_W)'(rowm1_s) * (2*COORD_W)'(rw_q);
      col_a_q   <= col_i;
      neg_a_q   <= error_negative_i;
      diff_a_q  <= local_difference_i;
    end
  end

  // stage a: sample index, sign correction, init value
  logic [T_W-1:0]            t_b_q;
  logic signed [V_W-1:0]     dif_b_q, dif_c_q, diffx_a;
  logic [WEIGHT_W-1:0]       ival_b_q, ival_c_q, ival_d_q, ival_a;
  logic [6:0]                sh3_a;

  always_comb begin
    diffx_a = V_W'(diff_a_q);
    sh3_a   = {2'b00, ctl_a_q.comp} * 7'd3;
    ival_a  = inter_a_q ? ((WEIGHT_W'(7) << (res_sat - 5'd3)) >> sh3_a) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (open_b) begin
      ctl_b_q  <= ctl_a_q;
      addr_b_q <= addr_a_q;
      off_b_q  <= off_a_q;
      t_b_q    <= T_W'(prod_a_q) + T_W'(col_a_q);
      dif_b_q  <= neg_a_q ? -diffx_a : diffx_a;
      ival_b_q <= ival_a;
    end
  end

  // stage b: scaling exponent
  logic [T_W-1:0]         q_b;
  logic signed [5:0]      span_b;
  logic                   sat_b;
  logic signed [6:0]      rho_b;
  logic signed [8:0]      e_wide_b;
  logic signed [E_W-1:0]  e_c_q;

  always_comb begin
    q_b      = t_b_q >> il_q;
    span_b   = 6'(ec_q) - 6'(ef_q);
    // rho never falls below the floor unless the ceiling is set below it, so only the ceiling can bind
    sat_b    = span_b[5] || (q_b > T_W'(span_b[4:0]));
    rho_b    = sat_b ? 7'(ec_q) : (7'(ef_q) + $signed({2'b00, q_b[4:0]}));
    e_wide_b = 9'(rho_b) + $signed({3'b000, sd_q}) - $signed({4'b0000, res_sat})
               + 9'(off_b_q);
  end

  always_ff @(posedge clk_i) begin
    if (open_c) begin
      ctl_c_q  <= ctl_b_q;
      addr_c_q <= addr_b_q;
      e_c_q    <= e_wide_b[E_W-1:0];
      dif_c_q  <= dif_b_q;
      ival_c_q <= ival_b_q;
    end
  end

  // stage c: scale the difference, read the stored weight
  logic signed [SV_W-1:0]     sv_c, sv_d_q;
  logic signed [WEIGHT_W-1:0] mem [DEPTH];
  logic signed [WEIGHT_W-1:0] rd_q, fwd_w_q, new_w;
  logic                       fwd_q;

  pwu_scale u_scale (
    .v_i  (dif_c_q),
    .e_i  (e_c_q),
    .sv_o (sv_c)
  );

  always_ff @(posedge clk_i) begin
    if (open_d) begin
      ctl_d_q  <= ctl_c_q;
      addr_d_q <= addr_c_q;
      sv_d_q   <= sv_c;
      ival_d_q <= ival_c_q;
      rd_q     <= mem[addr_c_q];
      fwd_w_q  <= new_w;
    end
    if (d_wr) begin
      mem[addr_d_q] <= new_w;
    end
  end

  // the write of the item ahead lands on the same edge as this read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (open_d) begin
      fwd_q <= d_wr && v_c_q && (addr_d_q == addr_c_q);
    end
  end

  // stage d: zero, hold or load, or round, accumulate and clip
  logic signed [WEIGHT_W-1:0] w_cur;
  logic signed [SUM_W-1:0]    r1, rr, sum, lim;

  always_comb begin
    w_cur = fwd_q ? fwd_w_q : rd_q;
    r1    = SUM_W'(sv_d_q) + SUM_W'(1);
    rr    = r1 >>> 1;
    sum   = rr + SUM_W'(w_cur);
    lim   = SUM_W'(1) << (res_sat + 5'd2);
    unique case (ctl_d_q.op)
      OP_ZERO: new_w = '0;
      OP_HOLD: new_w = w_cur;
      OP_LOAD: new_w = $signed(ival_d_q);
      OP_ADD: begin
        if (sum >= lim) begin
          new_w = WEIGHT_W'(lim - SUM_W'(1));
        end else if (sum < -lim) begin
          new_w = WEIGHT_W'(-lim);
        end else begin
          new_w = sum[WEIGHT_W-1:0];
        end
      end
    endcase
  end

  assign d_wr = d_move && ((ctl_d_q.op == OP_LOAD) || (ctl_d_q.op == OP_ADD));

  // output register
  logic signed [WEIGHT_W-1:0] weight_q;
  logic [COMP_W-1:0]          comp_q;
  logic                       applied_q;

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      weight_q  <= new_w;
      comp_q    <= ctl_d_q.comp;
      applied_q <= (ctl_d_q.op == OP_LOAD) || (ctl_d_q.op == OP_ADD);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign weight_o        = weight_q;
  assign component_out_o = comp_q;
  assign applied_o       = applied_q;

  // checks
  a_fwd_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_wr && v_c_q && (addr_d_q == addr_c_q)) |=> fwd_q)
    else $error("missed forwarding of same-entry write");

  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> v_d_q)
    else $error("forwarding flag without an item in the last stage");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_a_q && v_b_q && v_c_q && v_d_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("transaction taken while pipeline is full and stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_a_q)
    else $error("accepted transaction lost at entry");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_move |=> out_valid_q)
    else $error("result lost on the way to the output register");

endmodule

// ===== design/pwu_scale.sv =====
// ----------------------------------------------------------------------------
// pwu_scale
// Scales the sign-corrected local difference by 2^-e: arithmetic right shift
// for positive e, left shift saturated to +/-2^40 otherwise.
// ----------------------------------------------------------------------------
module pwu_scale (
  input  logic signed [pwu_pkg::V_W-1:0]  v_i,
  input  logic signed [pwu_pkg::E_W-1:0]  e_i,
  output logic signed [pwu_pkg::SV_W-1:0] sv_o
);
  import pwu_pkg::*;

  localparam int unsigned MAX_LSH = SCALE_LOG2 + 1;
  localparam int unsigned LW      = V_W + MAX_LSH;
  localparam logic signed [LW-1:0] SAT_POS = LW'(1) << SCALE_LOG2;
  localparam logic signed [LW-1:0] SAT_NEG = -SAT_POS;

  logic        [5:0]    rsh;
  logic        [5:0]    lsh;
  logic signed [V_W-1:0] rs;
  logic signed [LW-1:0]  vx;
  logic signed [LW-1:0]  ls;

  always_comb begin
    rsh  = '0;
    lsh  = '0;
    vx   = LW'(v_i);
    rs   = '0;
    ls   = '0;
    sv_o = '0;
    if (e_i > 8'sd0) begin
      // anything from the full width on leaves only sign bits
      rsh  = (e_i > E_W'(V_W)) ? 6'(V_W) : e_i[5:0];
      rs   = v_i >>> rsh;
      sv_o = SV_W'(rs);
    end else begin
      lsh  = (e_i < -$signed(E_W'(MAX_LSH))) ? 6'(MAX_LSH) : 6'(-e_i);
      ls   = vx <<< lsh;
      if (ls > SAT_POS) begin
        sv_o = SV_W'(SAT_POS);
      end else if (ls < SAT_NEG) begin
        sv_o = SV_W'(SAT_NEG);
      end else begin
        sv_o = ls[SV_W-1:0];
      end
    end
  end

endmodule
